/* hdl/cwe_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cwe_pkg
// Shared types, sizes and helpers for the candidate word enumerator.
// ---------------------------------------------------------------------------
package cwe_pkg;

  localparam int MAX_WORD   = 16;
  localparam int MAX_RANGES = 4;
  localparam int POS_W      = $clog2(MAX_WORD);
  localparam int LEN_W      = 5;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int SUM_W      = 10;
  localparam int OFF_W      = 64;
  localparam int DCNT_W     = $clog2(OFF_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_STARTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIZES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH  = 3'd4;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [OFF_W-1:0] start_offset;
  } in_item_t;

  typedef struct packed {
    logic [6:0]       out_char;
    logic [POS_W-1:0] char_position;
    logic             overflow;
    logic             last;
  } out_item_t;

  // one stored position: range index and offset within the range
  typedef struct packed {
    logic [1:0] range_index;
    logic [6:0] char_offset;
  } digit_t;

  // access to the digit store
  typedef struct packed {
    logic             clear;
    logic [POS_W-1:0] rd_addr;
    logic             we;
    logic [POS_W-1:0] wr_addr;
    digit_t           wr_data;
  } store_req_t;

  // effective size of range r: 0 reads as 1, above 128 reads as 128
  function automatic logic [7:0] range_size(input logic [31:0] sizes, input logic [1:0] r);
    logic [7:0] s;
    s = sizes[r*8 +: 8];
    if (s == 8'd0) s = 8'd1;
    if (s > 8'd128) s = 8'd128;
    return s;
  endfunction

  function automatic logic [6:0] range_start(input logic [27:0] starts, input logic [1:0] r);
    return starts[r*7 +: 7];
  endfunction

endpackage

/* hdl/cwe_divider.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cwe_divider
// Restoring serial divider: 64-bit dividend by a 10-bit divisor, one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module cwe_divider
  import cwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OFF_W-1:0] dividend,
  input  logic [SUM_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [OFF_W-1:0] quotient,
  output logic [SUM_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [OFF_W-1:0]  q_r, q_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W:0]    trial;

  // load on start, else one shift-subtract step while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, q_r[OFF_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = SUM_W'(trial - {1'b0, divisor});
        q_nxt   = {q_r[OFF_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SUM_W-1:0];
        q_nxt   = {q_r[OFF_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(OFF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* hdl/cwe_digit_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cwe_digit_store
// Synchronous memory of word positions with per-entry valid bits; an entry
// that is not valid reads as the first character of range 0.
// ---------------------------------------------------------------------------
module cwe_digit_store
  import cwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output digit_t     rd_digit
);

  digit_t              mem [MAX_WORD];
  logic [MAX_WORD-1:0] vld_r;
  digit_t              rdata_r;
  logic                rvld_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rdata_r <= mem[req.rd_addr];
  end

  // valid bits; a load clears the whole word at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.clear) begin
        vld_r <= '0;
      end else if (req.we) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      rvld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_digit = rvld_r ? rdata_r : '0;

endmodule

/* hdl/charset_word_enumerator_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charset_word_enumerator_core
// Mixed-radix word enumerator over up to four character ranges.
// ---------------------------------------------------------------------------
// One item is taken at a time. A step item reads and writes back one word
// position per cycle in the digit store, from the right until the carry
// stops, then streams the active characters at one per cycle while the
// output is not stalled. A load item runs the serial divider once per
// written digit. A load with zero offset and zero min_length returns no
// items.
module charset_word_enumerator_core
  import cwe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRD, S_SMOD, S_LCHK, S_DIV, S_LWR, S_ERD, S_EOUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       range_count_r;
  logic [27:0]      range_starts_r;
  logic [31:0]      range_sizes_r;
  logic [LEN_W-1:0] min_length_r;
  logic [LEN_W-1:0] word_length_r;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] w_r, w_nxt;
  logic             wneg_r, wneg_nxt;
  logic             ovf_r, ovf_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [2:0]       cnt;
  logic [LEN_W-1:0] size;
  logic [LEN_W-1:0] first;
  logic [SUM_W-1:0] sum;
  store_req_t       sreq;
  digit_t           dg;
  logic             div_start, div_busy, div_done;
  logic [OFF_W-1:0] div_q;
  logic [SUM_W-1:0] div_rem;
  logic [SUM_W-1:0] dsub;
  logic [1:0]       dr;
  logic [2:0]       idx;
  logic [7:0]       o_inc;
  logic             can_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r  <= 3'd1;
      range_starts_r <= 28'd48;
      range_sizes_r  <= 32'd10;
      min_length_r   <= 5'd1;
      word_length_r  <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_COUNT:  range_count_r  <= cfg_data[2:0];
        REG_RANGE_STARTS: range_starts_r <= cfg_data[27:0];
        REG_RANGE_SIZES:  range_sizes_r  <= cfg_data[31:0];
        REG_MIN_LENGTH:   min_length_r   <= cfg_data[4:0];
        REG_WORD_LENGTH:  word_length_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective settings
  always_comb begin
    cnt = range_count_r;
    if (cnt == 3'd0) cnt = 3'd1;
    if (cnt > 3'(MAX_RANGES)) cnt = 3'(MAX_RANGES);
    size = word_length_r;
    if (size == '0) size = LEN_W'(1);
    if (size > LEN_W'(MAX_WORD)) size = LEN_W'(MAX_WORD);
    sum = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (3'(i) < cnt) sum = sum + SUM_W'(range_size(range_sizes_r, 2'(i)));
    end
  end

  assign first = size - len_r;

  // split a remainder into range index and offset
  always_comb begin
    dsub = div_rem;
    dr   = '0;
    for (int i = 0; i < MAX_RANGES - 1; i++) begin
      if ((3'(dr) + 3'd1 < cnt) &&
          (dsub >= SUM_W'(range_size(range_sizes_r, dr))) &&
          (dr == 2'(i))) begin
        dsub = dsub - SUM_W'(range_size(range_sizes_r, dr));
        dr   = dr + 2'd1;
      end
    end
  end

  cwe_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (off_r),
    .divisor   (sum),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  cwe_digit_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sreq),
    .rd_digit (dg)
  );

  assign idx      = {1'b0, dg.range_index};
  assign o_inc    = {1'b0, dg.char_offset} + 8'd1;
  assign can_load = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    w_nxt         = w_r;
    wneg_nxt      = wneg_r;
    ovf_nxt       = ovf_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    div_start     = 1'b0;
    sreq          = '0;
    sreq.rd_addr  = w_r;
    sreq.wr_addr  = w_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ovf_nxt  = 1'b0;
          w_nxt    = POS_W'(size - LEN_W'(1));
          wneg_nxt = 1'b0;
          off_nxt  = in_item.start_offset;
          if (in_item.req_type == REQ_LOAD) begin
            sreq.clear = 1'b1;
            len_nxt    = (min_length_r > size) ? size : min_length_r;
            state_nxt  = S_LCHK;
          end else begin
            len_nxt   = (len_r > size) ? size : len_r;
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SMOD;
      end
      S_SMOD: begin
        if ({1'b0, w_r} < first) len_nxt = len_r + LEN_W'(1);
        sreq.we = 1'b1;
        if ((idx < cnt) && (o_inc < range_size(range_sizes_r, dg.range_index))) begin
          sreq.wr_data = {dg.range_index, o_inc[6:0]};
          state_nxt    = S_ERD;
        end else if (idx + 3'd1 < cnt) begin
          sreq.wr_data = {dg.range_index + 2'd1, 7'd0};
          state_nxt    = S_ERD;
        end else begin
          sreq.wr_data = '0;
          if (w_r == '0) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_ERD;
          end else begin
            w_nxt        = w_r - 1'b1;
            sreq.rd_addr = w_r - 1'b1;
          end
        end
      end
      S_LCHK: begin
        if (off_r == '0) begin
          state_nxt = S_ERD;
        end else if (wneg_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_ERD;
        end else begin
          if ({1'b0, w_r} < first) len_nxt = len_r + LEN_W'(1);
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_LWR;
      end
      S_LWR: begin
        sreq.we      = 1'b1;
        sreq.wr_data = {dr, dsub[6:0]};
        off_nxt      = div_q;
        if (w_r == '0) wneg_nxt = 1'b1;
        else w_nxt = w_r - 1'b1;
        state_nxt = S_LCHK;
      end
      S_ERD: begin
        w_nxt        = first[POS_W-1:0];
        sreq.rd_addr = first[POS_W-1:0];
        state_nxt    = (len_r == '0) ? S_IDLE : S_EOUT;
      end
      S_EOUT: begin
        if (can_load) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.out_char      = range_start(range_starts_r, dg.range_index)
                                       + dg.char_offset;
          out_item_nxt.char_position = POS_W'({1'b0, w_r} - first);
          out_item_nxt.overflow      = ovf_r;
          out_item_nxt.last          = ({1'b0, w_r} == size - LEN_W'(1));
          sreq.rd_addr               = w_r + 1'b1;
          w_nxt                      = w_r + 1'b1;
          if ({1'b0, w_r} == size - LEN_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(1);
      ovf_r       <= 1'b0;
      wneg_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      wneg_r      <= wneg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    off_r      <= off_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // divider only runs during a load digit
  a_div_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside load division");

  // store writes come only from the step update or the load digit write
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    sreq.we |-> (state_r == S_SMOD || state_r == S_LWR))
    else $error("digit store written in wrong state");

  // streaming only happens for a non-empty word
  a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EOUT) |-> (len_r != '0 && len_r <= size))
    else $error("streaming with bad word length");

endmodule
